/* rtl/stp_ramp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper ramp package
// Shared widths, reset values, command codes and control types for the
// trapezoidal stepper speed profile generator.
// ----------------------------------------------------------------------------
package stp_ramp_pkg;

  // Field and register widths.
  localparam int COUNT_WIDTH  = 15;
  localparam int SPEED_WIDTH  = 16;
  localparam int ACCEL_WIDTH  = 8;
  localparam int TCLK_WIDTH   = 24;
  localparam int PERIOD_WIDTH = 16;
  localparam int KIND_WIDTH   = 2;
  localparam int APB_ADDR_WIDTH = 4;
  localparam int APB_DATA_WIDTH = 32;

  // Register reset values.
  localparam int MAX_SPEED_RESET_INT   = 1000;
  localparam int ACCEL_STEP_RESET_INT  = 10;
  localparam int TIMER_CLOCK_RESET_INT = 62500;
  localparam int MIN_SPEED_INT         = 245;

  localparam logic [SPEED_WIDTH-1:0] MAX_SPEED_RESET   = SPEED_WIDTH'(MAX_SPEED_RESET_INT);
  localparam logic [ACCEL_WIDTH-1:0] ACCEL_STEP_RESET  = ACCEL_WIDTH'(ACCEL_STEP_RESET_INT);
  localparam logic [TCLK_WIDTH-1:0]  TIMER_CLOCK_RESET = TCLK_WIDTH'(TIMER_CLOCK_RESET_INT);

  // Slowest running speed, also the speed after a move ends.
  localparam logic [SPEED_WIDTH-1:0] MIN_SPEED = SPEED_WIDTH'(MIN_SPEED_INT);

  // Step period that matches the reset timer clock at the slowest speed.
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET =
    PERIOD_WIDTH'(TIMER_CLOCK_RESET_INT / MIN_SPEED_INT);

  // Event codes of an incoming command.
  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_START = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_RAMP  = 2'd2
  } kind_t;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_MAX_SPEED   = 2'd0,
    REG_ACCEL_STEP  = 2'd1,
    REG_TIMER_CLOCK = 2'd2
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_start;
    logic load_period;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_status_t;

endpackage
`default_nettype wire

/* rtl/stp_cmd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper ramp command channel
// Valid/ready channel that carries one event into the profile generator.
// ----------------------------------------------------------------------------
interface stp_cmd_if;
  import stp_ramp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KIND_WIDTH-1:0]  kind;
  logic [COUNT_WIDTH-1:0] step_count;
  logic                   move_direction;

  modport source (output valid, kind, step_count, move_direction, input ready);
  modport sink   (input valid, kind, step_count, move_direction, output ready);
endinterface
`default_nettype wire

/* rtl/stp_res_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper ramp result channel
// Valid/ready channel that carries one result per event out of the generator.
// ----------------------------------------------------------------------------
interface stp_res_if;
  import stp_ramp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    step_pulse;
  logic                    dir_level;
  logic [PERIOD_WIDTH-1:0] period_ticks;
  logic [SPEED_WIDTH-1:0]  speed_now;
  logic                    busy_res;
  logic                    move_done;

  modport source (output valid, step_pulse, dir_level, period_ticks, speed_now,
                  busy_res, move_done, input ready);
  modport sink   (input valid, step_pulse, dir_level, period_ticks, speed_now,
                  busy_res, move_done, output ready);
endinterface
`default_nettype wire

/* rtl/stp_ramp_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper ramp divider
// Restoring bit-serial divider, one quotient bit per cycle. A zero divisor
// gives an all-ones quotient.
// ----------------------------------------------------------------------------
module stp_ramp_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [stp_ramp_pkg::TCLK_WIDTH-1:0]  dividend,
  input  logic [stp_ramp_pkg::SPEED_WIDTH-1:0] divisor,
  output logic                                 done,
  output logic [stp_ramp_pkg::TCLK_WIDTH-1:0]  quotient
);
  import stp_ramp_pkg::*;

  localparam int DIV_STEPS     = TCLK_WIDTH;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

  logic                     busy;
  logic [DIV_CNT_WIDTH-1:0] cnt;
  logic [SPEED_WIDTH-1:0]   rem;
  logic [SPEED_WIDTH-1:0]   dsr;
  logic [TCLK_WIDTH-1:0]    dvd;

  logic [SPEED_WIDTH:0]     shifted;
  logic [SPEED_WIDTH:0]     trial;
  logic                     fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign shifted = {rem, dvd[TCLK_WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Remainder and shifting dividend, which collects the quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dvd <= dividend;
    end else if (busy) begin
      rem <= fits ? trial[SPEED_WIDTH-1:0] : shifted[SPEED_WIDTH-1:0];
      dvd <= {dvd[TCLK_WIDTH-2:0], fits};
    end
  end

  assign quotient = dvd;

endmodule
`default_nettype wire

/* rtl/stp_ramp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper ramp datapath
// Move state, ramp arithmetic, step period division and the result register.
// ----------------------------------------------------------------------------
module stp_ramp_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  stp_ramp_pkg::ctrl_cmd_t               cmd,
  output stp_ramp_pkg::dp_status_t              status,
  input  logic [stp_ramp_pkg::KIND_WIDTH-1:0]   in_kind,
  input  logic [stp_ramp_pkg::COUNT_WIDTH-1:0]  in_step_count,
  input  logic                                  in_move_direction,
  input  logic [stp_ramp_pkg::SPEED_WIDTH-1:0]  max_speed,
  input  logic [stp_ramp_pkg::ACCEL_WIDTH-1:0]  accel_step,
  input  logic [stp_ramp_pkg::TCLK_WIDTH-1:0]   timer_clock,
  output logic                                  step_pulse,
  output logic                                  dir_level,
  output logic [stp_ramp_pkg::PERIOD_WIDTH-1:0] period_ticks,
  output logic [stp_ramp_pkg::SPEED_WIDTH-1:0]  speed_now,
  output logic                                  busy_res,
  output logic                                  move_done
);
  import stp_ramp_pkg::*;

  // Move state.
  logic [COUNT_WIDTH-1:0]  total_steps, total_steps_next;
  logic [COUNT_WIDTH-1:0]  steps_done, steps_done_next;
  logic [SPEED_WIDTH-1:0]  speed, speed_next;
  logic                    accelerating, accelerating_next;
  logic                    decelerating, decelerating_next;
  logic                    moving, moving_next;
  logic                    dir_reg, dir_reg_next;
  logic [PERIOD_WIDTH-1:0] period_reg;
  logic                    res_pulse, res_pulse_next;
  logic                    res_done, res_done_next;

  // Ramp arithmetic.
  logic [COUNT_WIDTH+2:0]  five_done;
  logic [COUNT_WIDTH+2:0]  four_total;
  logic [COUNT_WIDTH+2:0]  total_ext;
  logic [SPEED_WIDTH:0]    accel_ext;
  logic [SPEED_WIDTH:0]    speed_sum;
  logic [SPEED_WIDTH-1:0]  speed_above_min;
  logic [SPEED_WIDTH-1:0]  speed_acc;
  logic [COUNT_WIDTH-1:0]  steps_inc;

  // Divider.
  logic                    div_done;
  logic [TCLK_WIDTH-1:0]   div_quot;

  // Fractions of the move as exact integer compares.
  assign five_done  = {1'b0, steps_done, 2'b00} + {3'b000, steps_done};
  assign four_total = {1'b0, total_steps, 2'b00};
  assign total_ext  = {3'b000, total_steps};
  assign accel_ext  = {{(SPEED_WIDTH + 1 - ACCEL_WIDTH){1'b0}}, accel_step};
  assign speed_sum  = {1'b0, speed} + accel_ext;
  assign speed_above_min = speed - MIN_SPEED;
  assign steps_inc  = steps_done + 1'b1;

  // Accelerated speed, saturated at the top speed.
  always_comb begin
    speed_acc = speed;
    if (speed < max_speed) begin
      speed_acc = (speed_sum > {1'b0, max_speed}) ? max_speed : speed_sum[SPEED_WIDTH-1:0];
    end
  end

  // State update for an accepted event.
  always_comb begin
    total_steps_next  = total_steps;
    steps_done_next   = steps_done;
    speed_next        = speed;
    accelerating_next = accelerating;
    decelerating_next = decelerating;
    moving_next       = moving;
    dir_reg_next      = dir_reg;
    res_pulse_next    = 1'b0;
    res_done_next     = 1'b0;
    unique case (in_kind)
      KIND_START: begin
        if (in_step_count != '0) begin
          dir_reg_next      = in_move_direction;
          total_steps_next  = in_step_count;
          accelerating_next = 1'b1;
          moving_next       = 1'b1;
        end
      end
      KIND_STEP: begin
        if (moving) begin
          res_pulse_next  = 1'b1;
          steps_done_next = steps_inc;
          if (steps_inc == total_steps) begin
            moving_next       = 1'b0;
            res_done_next     = 1'b1;
            speed_next        = MIN_SPEED;
            steps_done_next   = '0;
            accelerating_next = 1'b0;
            decelerating_next = 1'b0;
          end
        end
      end
      KIND_RAMP: begin
        if (moving) begin
          priority if (accelerating && (five_done < total_ext)) begin
            speed_next        = speed_acc;
            accelerating_next = (speed_acc != max_speed);
          end else if (!decelerating && (five_done > four_total)) begin
            accelerating_next = 1'b0;
            decelerating_next = 1'b1;
          end else if (decelerating) begin
            if (speed > MIN_SPEED) begin
              speed_next = ({1'b0, speed_above_min} > accel_ext) ?
                           speed - accel_ext[SPEED_WIDTH-1:0] : MIN_SPEED;
            end else begin
              decelerating_next = 1'b0;
            end
          end else begin
            speed_next = speed;
          end
        end
      end
      default: begin
        // The unused code leaves the state as it is.
      end
    endcase
  end

  // Move state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_steps  <= '0;
      steps_done   <= '0;
      speed        <= MIN_SPEED;
      accelerating <= 1'b0;
      decelerating <= 1'b0;
      moving       <= 1'b0;
      dir_reg      <= 1'b0;
    end else if (cmd.accept) begin
      total_steps  <= total_steps_next;
      steps_done   <= steps_done_next;
      speed        <= speed_next;
      accelerating <= accelerating_next;
      decelerating <= decelerating_next;
      moving       <= moving_next;
      dir_reg      <= dir_reg_next;
    end
  end

  // Per-event flags, held until the result is loaded.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_pulse <= res_pulse_next;
      res_done  <= res_done_next;
    end
  end

  // Step period: timer clock over the speed that the step leaves behind.
  stp_ramp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (timer_clock),
    .divisor  (speed_next),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Period register, saturated to the compare width.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_reg <= PERIOD_RESET;
    end else if (cmd.load_period) begin
      period_reg <= (div_quot[TCLK_WIDTH-1:PERIOD_WIDTH] != '0) ?
                    {PERIOD_WIDTH{1'b1}} : div_quot[PERIOD_WIDTH-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      step_pulse   <= res_pulse;
      dir_level    <= dir_reg;
      period_ticks <= period_reg;
      speed_now    <= speed;
      busy_res     <= moving;
      move_done    <= res_done;
    end
  end

  // Status to the controller.
  assign status.need_div = (in_kind == KIND_STEP) && moving;
  assign status.div_done = div_done;

endmodule
`default_nettype wire

/* rtl/stp_ramp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper ramp controller
// Sequences one event at a time: accept, optional period division, then
// handoff of the result to the output register.
// ----------------------------------------------------------------------------
module stp_ramp_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     out_ready,
  input  stp_ramp_pkg::dp_status_t status,
  output logic                     in_ready,
  output logic                     out_valid,
  output stp_ramp_pkg::ctrl_cmd_t  cmd
);
  import stp_ramp_pkg::*;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = status.need_div ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.div_start   = 1'b0;
    cmd.load_period = 1'b0;
    cmd.emit        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.accept    = accept;
        cmd.div_start = accept && status.need_div;
      end
      ST_DIV: begin
        cmd.load_period = status.div_done;
      end
      ST_EMIT: begin
        cmd.emit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The result is valid from its load until the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* rtl/stepper_trapezoid_ramp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper trapezoidal ramp generator
// Top level: configuration registers, controller, datapath and channels.
// ----------------------------------------------------------------------------
// The block takes one event per transfer on cmd (start a move, step tick or
// ramp tick) and returns exactly one result per event on res. A start, a
// ramp tick, a tick while idle or the unused code goes from accept to the
// result load, which waits for a free output register. A step tick during
// a move reloads the step period through a bit-serial divider that
// produces one quotient bit per cycle: accept, 24 divider iterations,
// period load, result load. One event is in work at a time; the next event
// is taken as soon as the previous result sits in the output register, even
// if res has not yet taken it. Configuration is to be written over the APB
// port only while no event is in work; the block itself does not enforce this.
module stepper_trapezoid_ramp (
  input  logic                                    clk,
  input  logic                                    rst,
  stp_cmd_if.sink                                 cmd,
  stp_res_if.source                               res,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [stp_ramp_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [stp_ramp_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [stp_ramp_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                    pready
);
  import stp_ramp_pkg::*;

  logic [SPEED_WIDTH-1:0] max_speed;
  logic [ACCEL_WIDTH-1:0] accel_step;
  logic [TCLK_WIDTH-1:0]  timer_clock;
  logic                   cfg_write;
  logic [1:0]             reg_index;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed   <= MAX_SPEED_RESET;
      accel_step  <= ACCEL_STEP_RESET;
      timer_clock <= TIMER_CLOCK_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_MAX_SPEED:   max_speed   <= pwdata[SPEED_WIDTH-1:0];
        REG_ACCEL_STEP:  accel_step  <= pwdata[ACCEL_WIDTH-1:0];
        REG_TIMER_CLOCK: timer_clock <= pwdata[TCLK_WIDTH-1:0];
        default: begin
          // Writes to unmapped addresses are dropped.
        end
      endcase
    end
  end

  // Register readback.
  always_comb begin
    prdata = '0;
    unique case (reg_index)
      REG_MAX_SPEED:   prdata = {{(APB_DATA_WIDTH - SPEED_WIDTH){1'b0}}, max_speed};
      REG_ACCEL_STEP:  prdata = {{(APB_DATA_WIDTH - ACCEL_WIDTH){1'b0}}, accel_step};
      REG_TIMER_CLOCK: prdata = {{(APB_DATA_WIDTH - TCLK_WIDTH){1'b0}}, timer_clock};
      default:         prdata = '0;
    endcase
  end

  // Controller.
  stp_ramp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .out_ready (res.ready),
    .status    (dp_status),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .cmd       (ctrl_cmd)
  );

  // Datapath.
  stp_ramp_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (ctrl_cmd),
    .status            (dp_status),
    .in_kind           (cmd.kind),
    .in_step_count     (cmd.step_count),
    .in_move_direction (cmd.move_direction),
    .max_speed         (max_speed),
    .accel_step        (accel_step),
    .timer_clock       (timer_clock),
    .step_pulse        (res.step_pulse),
    .dir_level         (res.dir_level),
    .period_ticks      (res.period_ticks),
    .speed_now         (res.speed_now),
    .busy_res          (res.busy_res),
    .move_done         (res.move_done)
  );

  // A step tick during a move keeps the block busy while the period divides.
  a_step_holds_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && dp_status.need_div) |=> !cmd.ready)
    else $error("step tick during a move did not hold off the next command");

  // The speed never drops below the slowest running speed.
  a_speed_floor: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.speed_now >= MIN_SPEED))
    else $error("reported speed below the minimum speed");

  // A finished move is always reported on a step pulse with the block idle.
  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.move_done) |-> (res.step_pulse && !res.busy_res))
    else $error("move completion reported without a step pulse or while busy");

endmodule
`default_nettype wire
